// ===== hdl/rcq_pkg.sv =====
// Shared types, constants and codes of the reciprocal coefficient quantizer.
package rcq_pkg;

  // Table geometry and fixed field widths.
  localparam int unsigned TABLE_DEPTH    = 64;
  localparam int unsigned ADDR_W         = $clog2(TABLE_DEPTH);
  localparam int unsigned COEF_BITS      = 16;
  localparam int unsigned STEP_W         = 16;
  localparam int unsigned RESULT_W       = 32;
  localparam int unsigned SHIFT_BITS_DEF = 16;

  // Action codes of an input item.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_PROC = 1'b1;

  // Mode register codes.
  localparam logic MODE_QUANT   = 1'b0;
  localparam logic MODE_DEQUANT = 1'b1;

  // Input item.
  typedef struct packed {
    logic                        action;
    logic [ADDR_W-1:0]           position;
    logic [STEP_W-1:0]           table_value;
    logic signed [COEF_BITS-1:0] coefficient;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [ADDR_W-1:0]          out_position;
    logic signed [RESULT_W-1:0] result_value;
  } out_item_t;

  // Larger of two widths, used when sizing datapaths at elaboration.
  function automatic int unsigned max_w(input int unsigned a, input int unsigned b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== hdl/rcq_divider.sv =====
// Bit-serial restoring divider that turns a quantization step into its rounded reciprocal.
module rcq_divider #(
  parameter int unsigned SHIFT_BITS = rcq_pkg::SHIFT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [rcq_pkg::ADDR_W-1:0]     addr_i,
  input  logic [rcq_pkg::STEP_W-1:0]     value_i,
  output logic                           busy_o,
  output logic                           wr_en_o,
  output logic [rcq_pkg::ADDR_W-1:0]     wr_addr_o,
  output logic [rcq_pkg::STEP_W-1:0]     wr_step_o,
  output logic [SHIFT_BITS:0]            wr_recip_o
);

  localparam int unsigned STEP_W  = rcq_pkg::STEP_W;
  localparam int unsigned NUM_W   = rcq_pkg::max_w(SHIFT_BITS, STEP_W) + 1;
  localparam int unsigned RECIP_W = SHIFT_BITS + 1;
  localparam int unsigned CNT_W   = $clog2(NUM_W + 1);
  localparam logic [NUM_W-1:0] ONE_SHIFTED = NUM_W'(1) << SHIFT_BITS;

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [NUM_W-1:0]          num_q, num_d;
  logic [NUM_W-1:0]          quo_q, quo_d;
  logic [STEP_W-1:0]         rem_q, rem_d;
  logic [STEP_W-1:0]         div_q, div_d;
  logic [rcq_pkg::ADDR_W-1:0] addr_q, addr_d;
  logic [STEP_W-1:0]         step_fix;
  logic [STEP_W:0]           trial;
  logic                      fits;

  // A zero step is stored as one so that the divisor never vanishes.
  assign step_fix = (value_i == '0) ? STEP_W'(1) : value_i;

  // One quotient bit per cycle: shift in the next numerator bit and try a subtract.
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign fits  = (trial >= {1'b0, div_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    addr_d = addr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      num_d  = ONE_SHIFTED + NUM_W'(step_fix >> 1);
      quo_d  = '0;
      rem_d  = '0;
      div_d  = step_fix;
      addr_d = addr_i;
    end else if (busy_q) begin
      num_d = num_q << 1;
      quo_d = {quo_q[NUM_W-2:0], fits};
      rem_d = fits ? STEP_W'(trial - {1'b0, div_q}) : trial[STEP_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working registers of the division.
  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
    addr_q <= addr_d;
  end

  // The write-back cycle still counts as busy so that no read can pass it.
  assign busy_o     = busy_q | done_q;
  assign wr_en_o    = done_q;
  assign wr_addr_o  = addr_q;
  assign wr_step_o  = div_q;
  assign wr_recip_o = quo_q[RECIP_W-1:0];

endmodule

// ===== hdl/rcq_table.sv =====
// Step and reciprocal tables: one write port, one registered read port.
module rcq_table #(
  parameter int unsigned SHIFT_BITS = rcq_pkg::SHIFT_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [rcq_pkg::ADDR_W-1:0] wr_addr_i,
  input  logic [rcq_pkg::STEP_W-1:0] wr_step_i,
  input  logic [SHIFT_BITS:0]        wr_recip_i,
  input  logic                       rd_en_i,
  input  logic [rcq_pkg::ADDR_W-1:0] rd_addr_i,
  output logic [rcq_pkg::STEP_W-1:0] rd_step_o,
  output logic [SHIFT_BITS:0]        rd_recip_o
);

  logic [rcq_pkg::STEP_W-1:0] step_mem  [rcq_pkg::TABLE_DEPTH];
  logic [SHIFT_BITS:0]        recip_mem [rcq_pkg::TABLE_DEPTH];
  logic [rcq_pkg::STEP_W-1:0] rd_step_q;
  logic [SHIFT_BITS:0]        rd_recip_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      step_mem[wr_addr_i]  <= wr_step_i;
      recip_mem[wr_addr_i] <= wr_recip_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_step_q  <= step_mem[rd_addr_i];
      rd_recip_q <= recip_mem[rd_addr_i];
    end
  end

  assign rd_step_o  = rd_step_q;
  assign rd_recip_o = rd_recip_q;

endmodule

// ===== hdl/reciprocal_coefficient_quantizer.sv =====
// Top level: table lookup and multiply pipeline of the reciprocal coefficient quantizer.
// Coefficient items: one per cycle unless back-pressure or a load stalls input.
// The four stages (table read, operand select, multiply, scale and clamp) each stall alone.
// Load items: the serial divider holds off input until all quotient bits are computed
// and the reciprocal is written to the table.
// Reset clears the mode register and all valid flags; table contents are undefined until loaded.
module reciprocal_coefficient_quantizer #(
  parameter int unsigned SHIFT_BITS = rcq_pkg::SHIFT_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rcq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rcq_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);

  localparam int unsigned COEF_BITS = rcq_pkg::COEF_BITS;
  localparam int unsigned STEP_W    = rcq_pkg::STEP_W;
  localparam int unsigned ADDR_W    = rcq_pkg::ADDR_W;
  localparam int unsigned RESULT_W  = rcq_pkg::RESULT_W;
  localparam int unsigned RECIP_W   = SHIFT_BITS + 1;
  localparam int unsigned AW        = rcq_pkg::max_w(COEF_BITS, STEP_W) + 1;
  localparam int unsigned BW        = rcq_pkg::max_w(STEP_W, RECIP_W);
  localparam int unsigned PW        = AW + BW;
  localparam logic [PW-1:0] NEG_LIM = PW'(64'h0000_0000_8000_0000);
  localparam logic [PW-1:0] POS_LIM = PW'(64'h0000_0000_7FFF_FFFF);

  logic mode_q;

  logic en1, en2, en3, en4;
  logic in_acc, proc_acc, load_acc;
  logic div_busy;

  logic                  in_neg;
  logic [COEF_BITS-1:0]  in_mag;

  logic                  s1_v_q;
  logic [ADDR_W-1:0]     s1_pos_q;
  logic                  s1_neg_q;
  logic [COEF_BITS-1:0]  s1_mag_q;
  logic [STEP_W-1:0]     rd_step;
  logic [RECIP_W-1:0]    rd_recip;

  logic                  s2_v_q;
  logic [ADDR_W-1:0]     s2_pos_q;
  logic                  s2_neg_q;
  logic [AW-1:0]         s2_opa_q, s2_opa_d;
  logic [BW-1:0]         s2_opb_q, s2_opb_d;

  logic                  s3_v_q;
  logic [ADDR_W-1:0]     s3_pos_q;
  logic                  s3_neg_q;
  logic [PW-1:0]         s3_prod_q;

  logic                  out_valid_q;
  rcq_pkg::out_item_t    out_q, out_d;
  logic [PW-1:0]         level;

  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [STEP_W-1:0]     wr_step;
  logic [RECIP_W-1:0]    wr_recip;

  // Mode register; the port never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= rcq_pkg::MODE_QUANT;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // Each stage moves on when it is empty or the stage after it moves on.
  assign en4 = !out_valid_q || out_ready_i;
  assign en3 = !s3_v_q || en4;
  assign en2 = !s2_v_q || en3;
  assign en1 = !s1_v_q || en2;

  assign in_ready_o = en1 && !div_busy;
  assign in_acc     = in_valid_i && in_ready_o;
  assign proc_acc   = in_acc && (in_item_i.action == rcq_pkg::ACT_PROC);
  assign load_acc   = in_acc && (in_item_i.action == rcq_pkg::ACT_LOAD);

  // Sign and magnitude of the incoming coefficient.
  assign in_neg = in_item_i.coefficient[COEF_BITS-1];
  assign in_mag = in_neg ? (~in_item_i.coefficient + COEF_BITS'(1))
                         : in_item_i.coefficient;

  // Reciprocal computation for load items.
  rcq_divider #(
    .SHIFT_BITS(SHIFT_BITS)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (load_acc),
    .addr_i    (in_item_i.position),
    .value_i   (in_item_i.table_value),
    .busy_o    (div_busy),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_step_o (wr_step),
    .wr_recip_o(wr_recip)
  );

  // Table memories, read as a coefficient item is accepted.
  rcq_table #(
    .SHIFT_BITS(SHIFT_BITS)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_step_i (wr_step),
    .wr_recip_i(wr_recip),
    .rd_en_i   (proc_acc),
    .rd_addr_i (in_item_i.position),
    .rd_step_o (rd_step),
    .rd_recip_o(rd_recip)
  );

  // Operand selection: rounding offset and reciprocal, or plain step.
  always_comb begin
    unique case (mode_q)
      rcq_pkg::MODE_DEQUANT: begin
        s2_opa_d = AW'(s1_mag_q);
        s2_opb_d = BW'(rd_step);
      end
      default: begin
        s2_opa_d = AW'(s1_mag_q) + AW'(rd_step >> 1);
        s2_opb_d = BW'(rd_recip);
      end
    endcase
  end

  // Scaling, saturation to the result range and reapplying the sign.
  assign level = (mode_q == rcq_pkg::MODE_DEQUANT) ? s3_prod_q : (s3_prod_q >> SHIFT_BITS);

  always_comb begin
    out_d.out_position = s3_pos_q;
    if (s3_neg_q && (level != '0)) begin
      if (level > NEG_LIM) begin
        out_d.result_value = RESULT_W'(NEG_LIM);
      end else begin
        out_d.result_value = RESULT_W'(~level + PW'(1));
      end
    end else if (level > POS_LIM) begin
      out_d.result_value = RESULT_W'(POS_LIM);
    end else begin
      out_d.result_value = RESULT_W'(level);
    end
  end

  // Valid flags of the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) begin
        s1_v_q <= proc_acc;
      end
      if (en2) begin
        s2_v_q <= s1_v_q;
      end
      if (en3) begin
        s3_v_q <= s2_v_q;
      end
      if (en4) begin
        out_valid_q <= s3_v_q;
      end
    end
  end

  // Payload of the stages.
  always_ff @(posedge clk_i) begin
    if (proc_acc) begin
      s1_pos_q <= in_item_i.position;
      s1_neg_q <= in_neg;
      s1_mag_q <= in_mag;
    end
    if (en2 && s1_v_q) begin
      s2_pos_q <= s1_pos_q;
      s2_neg_q <= s1_neg_q;
      s2_opa_q <= s2_opa_d;
      s2_opb_q <= s2_opb_d;
    end
    if (en3 && s2_v_q) begin
      s3_pos_q  <= s2_pos_q;
      s3_neg_q  <= s2_neg_q;
      s3_prod_q <= PW'(s2_opa_q) * PW'(s2_opb_q);
    end
    if (en4 && s3_v_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== hdl/rcq_checker.sv =====
// Port-level checks of the reciprocal coefficient quantizer and their binding.
module rcq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input rcq_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input rcq_pkg::out_item_t out_item_o
);

  logic load_acc, proc_acc;

  assign load_acc = in_valid_i && in_ready_o && (in_item_i.action == rcq_pkg::ACT_LOAD);
  assign proc_acc = in_valid_i && in_ready_o && (in_item_i.action == rcq_pkg::ACT_PROC);

  // A waiting result item stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item withdrawn before it was taken");

  // A waiting result item keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("result item changed while stalled");

  // A table load occupies the divider, so input is held off for the following cycles.
  a_load_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_acc |=> !in_ready_o ##1 !in_ready_o)
    else $error("item accepted while the reciprocal was being computed");

  // With no back-pressure a coefficient item reaches the output.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_acc ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i |=> out_valid_o)
    else $error("coefficient result missing at the expected cycle");

endmodule

bind reciprocal_coefficient_quantizer rcq_checker u_rcq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_item_i  (in_item_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);
